[rtl/core/bavg_pkg.sv]
// ============================================================================
// bavg_pkg
// Shared types and constants of the battery ADC moving average unit.
// ============================================================================
`default_nettype none

package bavg_pkg;

    // Window geometry (window length is kept a power of two)
    localparam int WINDOW_LEN = 32;
    localparam int WIN_LOG2   = $clog2(WINDOW_LEN);

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int MV_W     = 16;
    localparam int PCT_W    = 7;
    localparam int SUM_W    = SAMPLE_W + WIN_LOG2;
    localparam int PROD_W   = SAMPLE_W + MV_W;

    // APB register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic {
        REG_FULL_SCALE = 1'b0,
        REG_EMPTY      = 1'b1
    } t_reg_idx;

    // Register reset values
    localparam logic [MV_W-1:0] FULL_SCALE_RST = MV_W'(6600);
    localparam logic [MV_W-1:0] EMPTY_RST      = MV_W'(3200);

    // Percent scaling: excess / 10 saturated at 100
    localparam int PCT_STEP_MV = 10;
    localparam int PCT_MAX     = 100;
    localparam int PCT_SAT_MV  = (PCT_MAX + 1) * PCT_STEP_MV;
    localparam int PCT_D_W     = $clog2(PCT_SAT_MV);
    localparam int PCT_RECIP   = 205;  // ~ 2^11 / 10, exact below the saturation point
    localparam int PCT_SHIFT   = 11;
    localparam int PCT_RCP_W   = 8;
    localparam int PCT_MUL_W   = PCT_D_W + PCT_RCP_W;

    // Control word from the window logic to each cell
    typedef struct packed {
        logic shift;   // a new word enters the chain
        logic prime;   // first word after reset: every cell takes the sample
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/core/battery_adc_moving_average_unit.sv]
// ============================================================================
// battery_adc_moving_average_unit
// 32-tap moving average of battery ADC samples with millivolt and percent out.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_ready / i_sample) takes one 16-bit ADC word per
//   accepted handshake. Output channel (o_valid / i_ready) returns one word per
//   input: o_average (window mean), o_battery_mv and o_percent.
//   Path: window sum register, then product, millivolt and output registers.
//   Throughput: one word per cycle while i_ready does not stall the output;
//   the running sum is updated once per word from the oldest tap of the cell
//   chain, scaling in a 3-stage pipe (multiply, divide by 65535, percent).
//   Stalls: each stage holds its word while the next is full; input is still
//   taken while a finished result waits, as long as a pipe stage is free.
//   Reset: the chain contents are undefined; the first word after reset is
//   loaded into every tap. full_scale_mv resets to 6600, empty_mv to 3200.
//   APB: full_scale_mv at 0x0, empty_mv at 0x4; write only while idle.
// ============================================================================
`default_nettype none

module battery_adc_moving_average_unit import bavg_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // sample input
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    // result output
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic      [SAMPLE_W-1:0] o_average,
    output logic      [MV_W-1:0]     o_battery_mv,
    output logic      [PCT_W-1:0]    o_percent,
    // APB configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready
);

    logic [MV_W-1:0]     r_full_scale_mv;
    logic [MV_W-1:0]     r_empty_mv;
    logic                w_wr;
    t_reg_idx            w_idx;
    logic                w_win_valid;
    logic                w_win_ready;
    logic [SAMPLE_W-1:0] w_win_avg;

    // register access
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale_mv <= FULL_SCALE_RST;
            r_empty_mv      <= EMPTY_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FULL_SCALE: r_full_scale_mv <= pwdata[MV_W-1:0];
                REG_EMPTY:      r_empty_mv      <= pwdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FULL_SCALE: prdata = {{(APB_DW-MV_W){1'b0}}, r_full_scale_mv};
            REG_EMPTY:      prdata = {{(APB_DW-MV_W){1'b0}}, r_empty_mv};
            default:        prdata = '0;
        endcase
    end

    // sample chain and running sum
    bavg_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (i_sample),
        .o_valid   (w_win_valid),
        .i_ready   (w_win_ready),
        .o_average (w_win_avg)
    );

    // scaling pipe
    bavg_scale u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_full_scale_mv (r_full_scale_mv),
        .i_empty_mv      (r_empty_mv),
        .i_valid         (w_win_valid),
        .o_ready         (w_win_ready),
        .i_average       (w_win_avg),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_average       (o_average),
        .o_battery_mv    (o_battery_mv),
        .o_percent       (o_percent)
    );

endmodule

`default_nettype wire

[rtl/core/bavg_cell.sv]
// ============================================================================
// bavg_cell
// One tap of the sample chain: holds one sample, passes it on each shift.
// ============================================================================
`default_nettype none

module bavg_cell import bavg_pkg::*; (
    input  wire logic                i_clk,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [SAMPLE_W-1:0] i_prev,
    output logic      [SAMPLE_W-1:0] o_data
);

    logic [SAMPLE_W-1:0] r_data;
    logic [SAMPLE_W-1:0] n_data;

    // take the neighbor's sample, or the new sample when priming
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_ctl.prime ? i_sample : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[rtl/core/bavg_window.sv]
// ============================================================================
// bavg_window
// Chain of sample cells plus the running window sum and the first pipe stage.
// ============================================================================
`default_nettype none

module bavg_window import bavg_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic      [SAMPLE_W-1:0] o_average
);

    logic                r_primed;
    logic                r_valid;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic                w_fire;
    t_cell_ctl           w_ctl;
    logic [SAMPLE_W-1:0] w_tap [0:WINDOW_LEN];

    assign o_ready = !r_valid || i_ready;
    assign w_fire  = i_valid && o_ready;

    assign w_ctl.shift = w_fire;
    assign w_ctl.prime = !r_primed;

    // sample chain: tap 0 is the incoming word, the last tap the oldest one
    assign w_tap[0] = i_sample;

    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
        bavg_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_sample (i_sample),
            .i_prev   (w_tap[g]),
            .o_data   (w_tap[g+1])
        );
    end

    // running sum: drop the oldest, add the newest
    always_comb begin
        n_sum = r_sum;
        if (w_fire) begin
            if (!r_primed) begin
                n_sum = {i_sample, {WIN_LOG2{1'b0}}};
            end else begin
                n_sum = r_sum - {{WIN_LOG2{1'b0}}, w_tap[WINDOW_LEN]}
                              + {{WIN_LOG2{1'b0}}, i_sample};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_valid  <= 1'b0;
            r_sum    <= '0;
        end else begin
            r_sum <= n_sum;
            if (w_fire) begin
                r_primed <= 1'b1;
                r_valid  <= 1'b1;
            end else if (i_ready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    // average = sum / WINDOW_LEN
    assign o_valid   = r_valid;
    assign o_average = r_sum[SUM_W-1:WIN_LOG2];

endmodule

`default_nettype wire

[rtl/core/bavg_scale.sv]
// ============================================================================
// bavg_scale
// Three-stage scaling pipe: average to millivolts, then to charge percent.
// ============================================================================
`default_nettype none

module bavg_scale import bavg_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [MV_W-1:0]     i_full_scale_mv,
    input  wire logic [MV_W-1:0]     i_empty_mv,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [SAMPLE_W-1:0] i_average,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic      [SAMPLE_W-1:0] o_average,
    output logic      [MV_W-1:0]     o_battery_mv,
    output logic      [PCT_W-1:0]    o_percent
);

    logic                 r_v_prod, r_v_mv, r_v_out;
    logic                 w_rdy_prod, w_rdy_mv, w_rdy_out;
    logic [PROD_W-1:0]    r_prod;
    logic [SAMPLE_W-1:0]  r_avg_prod, r_avg_mv, r_avg_out;
    logic [MV_W-1:0]      r_mv, r_mv_out;
    logic [PCT_W-1:0]     r_pct;
    logic [PROD_W-1:0]    w_div_sum;
    logic [MV_W-1:0]      w_mv;
    logic [MV_W:0]        w_excess;
    logic [PCT_MUL_W-1:0] w_pct_mul;
    logic [PCT_W-1:0]     w_pct;

    assign w_rdy_out  = !r_v_out  || i_ready;
    assign w_rdy_mv   = !r_v_mv   || w_rdy_out;
    assign w_rdy_prod = !r_v_prod || w_rdy_mv;
    assign o_ready    = w_rdy_prod;

    // x / 65535 = (x + (x >> 16) + 1) >> 16, exact for any 16x16 product
    assign w_div_sum = r_prod + {{MV_W{1'b0}}, r_prod[PROD_W-1:MV_W]} + PROD_W'(1);
    assign w_mv      = w_div_sum[PROD_W-1:MV_W];

    // excess over empty level, divided by 10 through a reciprocal
    assign w_excess  = {1'b0, r_mv} - {1'b0, i_empty_mv};
    assign w_pct_mul = PCT_MUL_W'(w_excess[PCT_D_W-1:0]) * PCT_MUL_W'(PCT_RECIP);

    always_comb begin
        if (w_excess[MV_W]) begin
            w_pct = '0;
        end else if (w_excess >= (MV_W+1)'(PCT_SAT_MV)) begin
            w_pct = PCT_W'(PCT_MAX);
        end else begin
            w_pct = w_pct_mul[PCT_SHIFT +: PCT_W];
        end
    end

    // pipe control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_mv   <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (w_rdy_prod) r_v_prod <= i_valid;
            if (w_rdy_mv)   r_v_mv   <= r_v_prod;
            if (w_rdy_out)  r_v_out  <= r_v_mv;
        end
    end

    // pipe payload
    always_ff @(posedge i_clk) begin
        if (w_rdy_prod) begin
            r_prod     <= PROD_W'(i_average) * PROD_W'(i_full_scale_mv);
            r_avg_prod <= i_average;
        end
        if (w_rdy_mv) begin
            r_mv     <= w_mv;
            r_avg_mv <= r_avg_prod;
        end
        if (w_rdy_out) begin
            r_pct     <= w_pct;
            r_mv_out  <= r_mv;
            r_avg_out <= r_avg_mv;
        end
    end

    assign o_valid      = r_v_out;
    assign o_average    = r_avg_out;
    assign o_battery_mv = r_mv_out;
    assign o_percent    = r_pct;

endmodule

`default_nettype wire
